### hdl/cdeq_pkg.sv
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared codes and control/status bundles for the circular deque.
// ----------------------------------------------------------------------------
package cdeq_pkg;

    // operation codes carried by cmd
    localparam logic [1:0] CMD_INS_FRONT = 2'd0;
    localparam logic [1:0] CMD_INS_REAR  = 2'd1;
    localparam logic [1:0] CMD_REM_FRONT = 2'd2;
    localparam logic [1:0] CMD_REM_REAR  = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STS_UNDERFLOW = 2'd2;

    localparam int unsigned WORD_W = 32;

    // controller -> datapath
    typedef struct packed {
        logic exec;     // perform the operation on the accepted transaction
        logic capture;  // latch the store read data into the result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_read; // the offered transaction is a removal that will succeed
    } dp_stat_t;

endpackage

### hdl/cdeq_ram.sv
// ----------------------------------------------------------------------------
// cdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdeq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/cdeq_datapath.sv
// ----------------------------------------------------------------------------
// cdeq_datapath
// Head/tail pointers, occupancy, store and result registers.
// ----------------------------------------------------------------------------
module cdeq_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cdeq_pkg::dp_cmd_t       ctl,
    output cdeq_pkg::dp_stat_t      sts,
    input  logic [1:0]              cmd,
    input  logic signed [31:0]      value,
    output logic signed [31:0]      data,
    output logic [1:0]              status,
    output logic                    is_empty,
    output logic                    is_full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL = OCC_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [OCC_W-1:0] occ_reg,  occ_next;
    logic [31:0]      data_reg;
    logic [1:0]       status_reg, status_next;
    logic             empty_reg, full_reg;

    logic             occ_zero, occ_full;
    logic [PTR_W-1:0] head_dn, head_up, tail_dn, tail_up;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [31:0]      rd_data;

    assign occ_zero = (occ_reg == '0);
    assign occ_full = (occ_reg == FULL);
    assign head_dn  = (head_reg == '0)   ? LAST : head_reg - 1'b1;
    assign head_up  = (head_reg == LAST) ? '0   : head_reg + 1'b1;
    assign tail_dn  = (tail_reg == '0)   ? LAST : tail_reg - 1'b1;
    assign tail_up  = (tail_reg == LAST) ? '0   : tail_reg + 1'b1;

    assign sts.needs_read = cmd[1] & ~occ_zero;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        status_next = cdeq_pkg::STS_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_addr     = head_reg;
        case (cmd)
            cdeq_pkg::CMD_INS_FRONT:
            begin
                if (occ_full)
                begin
                    status_next = cdeq_pkg::STS_OVERFLOW;
                end
                else
                begin
                    head_next = head_dn;
                    wr_addr   = head_dn;
                    wr_en     = ctl.exec;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            cdeq_pkg::CMD_INS_REAR:
            begin
                if (occ_full)
                begin
                    status_next = cdeq_pkg::STS_OVERFLOW;
                end
                else
                begin
                    tail_next = tail_up;
                    wr_addr   = tail_reg;
                    wr_en     = ctl.exec;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            cdeq_pkg::CMD_REM_FRONT:
            begin
                if (occ_zero)
                begin
                    status_next = cdeq_pkg::STS_UNDERFLOW;
                end
                else
                begin
                    rd_addr   = head_reg;
                    rd_en     = ctl.exec;
                    head_next = head_up;
                    occ_next  = occ_reg - 1'b1;
                end
            end
            default:
            begin
                if (occ_zero)
                begin
                    status_next = cdeq_pkg::STS_UNDERFLOW;
                end
                else
                begin
                    tail_next = tail_dn;
                    rd_addr   = tail_dn;
                    rd_en     = ctl.exec;
                    occ_next  = occ_reg - 1'b1;
                end
            end
        endcase
    end

    cdeq_ram #(
        .WIDTH (cdeq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            empty_reg <= 1'b1;
            full_reg  <= 1'b0;
        end
        else if (ctl.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            empty_reg <= (occ_next == '0);
            full_reg  <= (occ_next == FULL);
        end
    end

    // result payload; data is zero unless a removal's read is captured
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            data_reg   <= '0;
            status_reg <= status_next;
        end
        else if (ctl.capture)
        begin
            data_reg <= rd_data;
        end
    end

    assign data     = data_reg;
    assign status   = status_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

endmodule

### hdl/cdeq_ctrl.sv
// ----------------------------------------------------------------------------
// cdeq_ctrl
// Sequencer: accept, optional store read, present result.
// ----------------------------------------------------------------------------
module cdeq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cdeq_pkg::dp_stat_t  sts,
    output cdeq_pkg::dp_cmd_t   ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign ctl.exec    = in_ready & in_valid;
    assign ctl.capture = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.needs_read ? S_READ : S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/circular_double_ended_queue.sv
// Result: an insert or a failed removal shows its result in the cycle after acceptance;
//   a successful removal first goes through the store's registered read and the S_READ capture.
// Transactions: one at a time; a new one is accepted only after the pending result
//   has been taken on out_ready.
// Reset (rst_n, async, active low): deque empty, both pointers zero, no result pending;
//   store contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue of signed 32-bit words held in a circular RAM of DEPTH
// entries. Each transaction inserts at or removes from either end and
// returns one result with the removed word, a status and empty/full flags.
// ----------------------------------------------------------------------------
module circular_double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] data,
    output logic [1:0]         status,
    output logic               is_empty,
    output logic               is_full
);

    // Controller and datapath talk only through these two bundles.
    cdeq_pkg::dp_cmd_t  ctl;
    cdeq_pkg::dp_stat_t sts;

    // The sequencer accepts a transaction only in idle, so the offered cmd
    // and value are sampled by the datapath on the accepting edge itself:
    // pointers, occupancy and flags update there, an insert writes the
    // store there, and a removal launches its read there.
    cdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Result registers live in the datapath and hold steady while out_valid
    // waits for out_ready. Overflow and underflow leave the state untouched
    // and report zero data.
    cdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .cmd      (cmd),
        .value    (value),
        .data     (data),
        .status   (status),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

endmodule
